[design/ethernet_frame_classifier_unit_macros.svh]
// Assertion macros for the Ethernet frame classifier.
// Expects clk and rst in the scope of the module that uses them.
`ifndef ETHERNET_FRAME_CLASSIFIER_UNIT_MACROS_SVH
`define ETHERNET_FRAME_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EFC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("efc assertion failed");
`define EFC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("efc assertion failed");
`else
`define EFC_ASSERT_IMP(name, ante, cons)
`define EFC_ASSERT_NXT(name, ante, cons)
`endif
`endif

[design/efc_pkg.sv]
// Types and constants of the Ethernet frame classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;

  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  PROTO_TCP      = 8'h06;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

  localparam logic [5:0] POS_MAX        = 6'd63;
  localparam logic [5:0] ARP_MIN_BYTES  = 6'd42;
  localparam logic [5:0] IPV4_MIN_BYTES = 6'd34;

  localparam logic [5:0] POS_MAC_END   = 6'd6;
  localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [5:0] POS_IPLEN_HI  = 6'd16;
  localparam logic [5:0] POS_IPLEN_LO  = 6'd17;
  localparam logic [5:0] POS_ARPOP_HI  = 6'd20;
  localparam logic [5:0] POS_ARPOP_LO  = 6'd21;
  localparam logic [5:0] POS_PROTO     = 6'd23;
  localparam logic [5:0] POS_IPDST_LO  = 6'd30;
  localparam logic [5:0] POS_IPDST_HI  = 6'd33;
  localparam logic [5:0] POS_ARPTGT_LO = 6'd38;
  localparam logic [5:0] POS_ARPTGT_HI = 6'd41;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_ARP   = 2'd1;
  localparam logic [1:0] CLASS_TCP   = 2'd2;
  localparam logic [1:0] CLASS_UDP   = 2'd3;

  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  typedef struct packed {
    logic [15:0] ip_total_length;
    logic [1:0]  frame_class;
  } res_t;

endpackage
`default_nettype wire

[design/ethernet_frame_classifier_unit.sv]
// Ethernet frame classifier: captures header fields and classifies each frame.
// Depends on efc_pkg and ethernet_frame_classifier_unit_macros.svh.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tlast carry frame bytes, one word per byte,
//   starting at the destination MAC; s_tlast marks the final byte.
//   m_tvalid/m_tready/m_tdata carry one result word per frame.
//   cfg_we/cfg_index/cfg_data write own_mac (index 0) and own_ip (index 1).
// Result: the result word is registered in the output register when the frame's
//   last word is accepted, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while s_tready is high; capture state, field
//   compares and the result register all work on a single byte each clock.
// Reset: clears the byte counter, all captured fields, both station
//   registers and the valid flags of the output stages.
// Stall: an output register plus a one-entry skid register hold results;
//   s_tready drops only while the skid register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "ethernet_frame_classifier_unit_macros.svh"
module ethernet_frame_classifier_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  wire logic        s_tlast,   // frame_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [1:0] frame_class, [17:2] ip_total_length, zero pad
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic [47:0] own_mac;
  logic [31:0] own_ip;

  logic [5:0]  pos, pos_next;
  logic [47:0] dmac, dmac_next;
  logic [15:0] etype, etype_next;
  logic [15:0] arp_op, arp_op_next;
  logic [31:0] arp_tgt, arp_tgt_next;
  logic [15:0] ip_len, ip_len_next;
  logic [7:0]  ip_proto, ip_proto_next;
  logic [31:0] ip_dst, ip_dst_next;

  efc_pkg::res_t res;
  efc_pkg::res_t out_res, skid_res;
  logic          out_valid, skid_valid;
  logic          in_take, res_push, out_take;
  logic          arp_hit, ip_hit;

  assign s_tready = !skid_valid;
  assign in_take  = s_tvalid && s_tready;
  assign res_push = in_take && s_tlast;
  assign out_take = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efc_pkg::CFG_OWN_MAC: own_mac <= cfg_data;
        efc_pkg::CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
      endcase
    end
  end

  always_comb begin
    dmac_next     = dmac;
    etype_next    = etype;
    arp_op_next   = arp_op;
    arp_tgt_next  = arp_tgt;
    ip_len_next   = ip_len;
    ip_proto_next = ip_proto;
    ip_dst_next   = ip_dst;
    if (pos < efc_pkg::POS_MAC_END) begin
      dmac_next = {dmac[39:0], s_tdata};
    end else if (pos == efc_pkg::POS_ETYPE_HI || pos == efc_pkg::POS_ETYPE_LO) begin
      etype_next = {etype[7:0], s_tdata};
    end else if (pos == efc_pkg::POS_IPLEN_HI || pos == efc_pkg::POS_IPLEN_LO) begin
      ip_len_next = {ip_len[7:0], s_tdata};
    end else if (pos == efc_pkg::POS_ARPOP_HI || pos == efc_pkg::POS_ARPOP_LO) begin
      arp_op_next = {arp_op[7:0], s_tdata};
    end else if (pos == efc_pkg::POS_PROTO) begin
      ip_proto_next = s_tdata;
    end else if (pos >= efc_pkg::POS_IPDST_LO && pos <= efc_pkg::POS_IPDST_HI) begin
      ip_dst_next = {ip_dst[23:0], s_tdata};
    end else if (pos >= efc_pkg::POS_ARPTGT_LO && pos <= efc_pkg::POS_ARPTGT_HI) begin
      arp_tgt_next = {arp_tgt[23:0], s_tdata};
    end
    pos_next = (pos == efc_pkg::POS_MAX) ? pos : pos + 6'd1;
  end

  always_comb begin
    arp_hit = (etype_next == efc_pkg::ETYPE_ARP) && (pos_next >= efc_pkg::ARP_MIN_BYTES)
              && ((dmac_next == efc_pkg::BCAST_MAC) || (dmac_next == own_mac))
              && (arp_op_next == efc_pkg::ARP_OP_REQUEST) && (arp_tgt_next == own_ip);
    ip_hit  = (etype_next == efc_pkg::ETYPE_IPV4) && (pos_next >= efc_pkg::IPV4_MIN_BYTES)
              && (ip_dst_next == own_ip);
    res.frame_class     = efc_pkg::CLASS_OTHER;
    res.ip_total_length = '0;
    if (arp_hit) begin
      res.frame_class = efc_pkg::CLASS_ARP;
    end else if (ip_hit && ip_proto_next == efc_pkg::PROTO_TCP) begin
      res.frame_class     = efc_pkg::CLASS_TCP;
      res.ip_total_length = ip_len_next;
    end else if (ip_hit && ip_proto_next == efc_pkg::PROTO_UDP) begin
      res.frame_class     = efc_pkg::CLASS_UDP;
      res.ip_total_length = ip_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_push) begin
      pos      <= '0;
      dmac     <= '0;
      etype    <= '0;
      arp_op   <= '0;
      arp_tgt  <= '0;
      ip_len   <= '0;
      ip_proto <= '0;
      ip_dst   <= '0;
    end else if (in_take) begin
      pos      <= pos_next;
      dmac     <= dmac_next;
      etype    <= etype_next;
      arp_op   <= arp_op_next;
      arp_tgt  <= arp_tgt_next;
      ip_len   <= ip_len_next;
      ip_proto <= ip_proto_next;
      ip_dst   <= ip_dst_next;
    end
  end

  // hold a stalled result in the skid register, refill the output from it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_push) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      if (!out_valid || m_tready) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (out_take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  `EFC_ASSERT_IMP(a_skid_needs_out, skid_valid, out_valid)
  `EFC_ASSERT_IMP(a_len_zero_other,
    out_valid && (out_res.frame_class == efc_pkg::CLASS_OTHER ||
                  out_res.frame_class == efc_pkg::CLASS_ARP),
    out_res.ip_total_length == 16'd0)
  `EFC_ASSERT_NXT(a_clear_after_last, res_push, pos == 6'd0)
  `EFC_ASSERT_NXT(a_pos_advance, in_take && !s_tlast && pos != efc_pkg::POS_MAX,
    pos == $past(pos) + 6'd1)

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for ethernet_frame_classifier_unit: streams frames byte by byte and
// checks each result word against an in-bench classifier predictor.
// Depends on efc_pkg and the classifier RTL.
`timescale 1ns / 1ps
module tb;

  typedef logic [7:0] octets_t [$];

  localparam logic [47:0] STATION_MAC = 48'h02_1A_2B_3C_4D_5E;
  localparam logic [31:0] STATION_IP  = 32'hC0A8_0107;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] frame_byte
  logic        s_tlast;    // frame_last
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [1:0] frame_class, [17:2] ip_total_length, zero pad
  logic        cfg_we;
  logic        cfg_index;
  logic [47:0] cfg_data;

  ethernet_frame_classifier_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // classifier predictor state
  logic [47:0] station_mac;
  logic [31:0] station_ip;
  logic [5:0]  hdr_pos;
  logic [47:0] dmac_cap;
  logic [15:0] etype_cap;
  logic [15:0] arp_op_cap;
  logic [31:0] arp_tgt_cap;
  logic [15:0] ip_len_cap;
  logic [7:0]  ip_proto_cap;
  logic [31:0] ip_dst_cap;

  efc_pkg::res_t pending_class_q [$];
  int   fails;
  int   bytes_sent;
  int   frames_sent;
  int   class_seen [4];
  bit   quiet;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin : check_results
    efc_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_class_q.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        fails++;
      end else begin
        want = pending_class_q.pop_front();
        class_seen[want.frame_class]++;
        if (m_tdata[1:0] !== want.frame_class) begin
          $error("frame_class: expected %0d, got %0d", want.frame_class, m_tdata[1:0]);
          fails++;
        end
        if (m_tdata[17:2] !== want.ip_total_length) begin
          $error("ip_total_length: expected %h, got %h", want.ip_total_length, m_tdata[17:2]);
          fails++;
        end
        if (m_tdata[23:18] !== 6'd0) begin
          $error("pad: expected 0, got %h", m_tdata[23:18]);
          fails++;
        end
      end
    end
  end

  task automatic clear_capture;
    hdr_pos      = '0;
    dmac_cap     = '0;
    etype_cap    = '0;
    arp_op_cap   = '0;
    arp_tgt_cap  = '0;
    ip_len_cap   = '0;
    ip_proto_cap = '0;
    ip_dst_cap   = '0;
  endtask

  task automatic classify_byte(input logic [7:0] b, input logic last);
    efc_pkg::res_t r;
    if (hdr_pos < efc_pkg::POS_MAC_END) begin
      dmac_cap = {dmac_cap[39:0], b};
    end else if (hdr_pos == efc_pkg::POS_ETYPE_HI || hdr_pos == efc_pkg::POS_ETYPE_LO) begin
      etype_cap = {etype_cap[7:0], b};
    end else if (hdr_pos == efc_pkg::POS_IPLEN_HI || hdr_pos == efc_pkg::POS_IPLEN_LO) begin
      ip_len_cap = {ip_len_cap[7:0], b};
    end else if (hdr_pos == efc_pkg::POS_ARPOP_HI || hdr_pos == efc_pkg::POS_ARPOP_LO) begin
      arp_op_cap = {arp_op_cap[7:0], b};
    end else if (hdr_pos == efc_pkg::POS_PROTO) begin
      ip_proto_cap = b;
    end else if (hdr_pos >= efc_pkg::POS_IPDST_LO && hdr_pos <= efc_pkg::POS_IPDST_HI) begin
      ip_dst_cap = {ip_dst_cap[23:0], b};
    end else if (hdr_pos >= efc_pkg::POS_ARPTGT_LO && hdr_pos <= efc_pkg::POS_ARPTGT_HI) begin
      arp_tgt_cap = {arp_tgt_cap[23:0], b};
    end
    if (hdr_pos != efc_pkg::POS_MAX) hdr_pos = hdr_pos + 6'd1;
    if (last) begin
      r.frame_class = efc_pkg::CLASS_OTHER;
      r.ip_total_length = '0;
      if (etype_cap == efc_pkg::ETYPE_ARP) begin
        if (hdr_pos >= efc_pkg::ARP_MIN_BYTES &&
            (dmac_cap == efc_pkg::BCAST_MAC || dmac_cap == station_mac) &&
            arp_op_cap == efc_pkg::ARP_OP_REQUEST && arp_tgt_cap == station_ip)
          r.frame_class = efc_pkg::CLASS_ARP;
      end else if (etype_cap == efc_pkg::ETYPE_IPV4 && hdr_pos >= efc_pkg::IPV4_MIN_BYTES &&
                   ip_dst_cap == station_ip) begin
        if (ip_proto_cap == efc_pkg::PROTO_TCP) r.frame_class = efc_pkg::CLASS_TCP;
        else if (ip_proto_cap == efc_pkg::PROTO_UDP) r.frame_class = efc_pkg::CLASS_UDP;
        if (r.frame_class != efc_pkg::CLASS_OTHER) r.ip_total_length = ip_len_cap;
      end
      pending_class_q.push_back(r);
      clear_capture();
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(99) < 4 ? $urandom_range(2, 6) : 1) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input octets_t f);
    foreach (f[i]) push_word(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  function automatic octets_t build_frame(input logic [47:0] dmac, input logic [15:0] etype,
                                          input logic [15:0] ip_len, input logic [15:0] arp_op,
                                          input logic [7:0] proto, input logic [31:0] addr,
                                          input int len);
    octets_t f;
    logic [7:0] hdr [0:41];
    for (int i = 0; i < 42; i++) hdr[i] = 8'($urandom);
    for (int i = 0; i < 6; i++) hdr[i] = dmac[47 - 8 * i -: 8];
    {hdr[12], hdr[13]} = etype;
    {hdr[16], hdr[17]} = ip_len;
    {hdr[20], hdr[21]} = arp_op;
    hdr[23] = proto;
    {hdr[30], hdr[31], hdr[32], hdr[33]} = addr;
    {hdr[38], hdr[39], hdr[40], hdr[41]} = addr;
    for (int i = 0; i < len; i++) f.push_back(i < 42 ? hdr[i] : 8'($urandom));
    return f;
  endfunction

  task automatic wait_results_done;
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (pending_class_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (pending_class_q.size() != 0) begin
      $error("%0d results never arrived", pending_class_q.size());
      fails++;
      pending_class_q.delete();
    end
  endtask

  task automatic write_station(input logic [47:0] mac, input logic [31:0] ip);
    wait_results_done();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= efc_pkg::CFG_OWN_MAC;
    cfg_data  <= mac;
    @(posedge clk);
    cfg_index <= efc_pkg::CFG_OWN_IP;
    cfg_data  <= {16'h0, ip};
    @(posedge clk);
    cfg_we <= 1'b0;
    station_mac = mac;
    station_ip  = ip;
  endtask

  task automatic test_reset_station;
    send_frame(build_frame('0, efc_pkg::ETYPE_ARP, 16'h0, efc_pkg::ARP_OP_REQUEST,
                           efc_pkg::PROTO_TCP, 32'h0, 42));
    send_frame(build_frame(48'h1, efc_pkg::ETYPE_IPV4, 16'hFFFF, 16'h0, efc_pkg::PROTO_UDP,
                           32'h0, 34));
  endtask

  task automatic test_arp_requests;
    write_station(STATION_MAC, STATION_IP);
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 42));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 41));
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 60));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0, 16'h0002, 8'h0,
                           STATION_IP, 42));
    send_frame(build_frame(STATION_MAC ^ 48'h1, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 42));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP ^ 32'h8000_0000, 42));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP ^ 16'h0001, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 42));
  endtask

  task automatic test_ipv4_traffic;
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_IPV4, 16'h0000, 16'h0,
                           efc_pkg::PROTO_TCP, STATION_IP, 34));
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_IPV4, 16'h0040, 16'h0,
                           efc_pkg::PROTO_UDP, STATION_IP, 33));
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_IPV4, 16'hFFFF, 16'h0,
                           efc_pkg::PROTO_UDP, STATION_IP, 120));
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_IPV4, 16'h0054, 16'h0, 8'h01,
                           STATION_IP, 60));
    send_frame(build_frame(STATION_MAC, efc_pkg::ETYPE_IPV4, 16'h0054, 16'h0,
                           efc_pkg::PROTO_TCP, STATION_IP ^ 32'h1, 60));
    write_station('1, '1);
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, '1, 42));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_IPV4, 16'h8001, 16'h0,
                           efc_pkg::PROTO_TCP, '1, 64));
  endtask

  task automatic test_runt_and_long_frames;
    write_station(STATION_MAC, STATION_IP);
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 1));
    send_frame(build_frame('0, efc_pkg::ETYPE_ARP, 16'h0, efc_pkg::ARP_OP_REQUEST, 8'h0,
                           STATION_IP, 2));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_IPV4, 16'h0, 16'h0,
                           efc_pkg::PROTO_TCP, STATION_IP, 14));
    send_frame(build_frame(efc_pkg::BCAST_MAC, 16'h86DD, 16'h0, efc_pkg::ARP_OP_REQUEST,
                           efc_pkg::PROTO_UDP, STATION_IP, 60));
    send_frame(build_frame(efc_pkg::BCAST_MAC, efc_pkg::ETYPE_ARP, 16'h0,
                           efc_pkg::ARP_OP_REQUEST, 8'h0, STATION_IP, 100));
  endtask

  task automatic send_random_frame;
    int k;
    int r;
    int len;
    logic [47:0] dmac;
    logic [15:0] etype;
    logic [15:0] op;
    logic [7:0]  proto;
    logic [31:0] addr;
    k = $urandom_range(99);
    r = $urandom_range(99);
    if (r < 10) len = $urandom_range(1, 33);
    else if (r < 20) len = $urandom_range(34, 41);
    else if (r < 85) len = $urandom_range(42, 64);
    else len = $urandom_range(65, 120);
    r = $urandom_range(99);
    dmac = r < 40 ? efc_pkg::BCAST_MAC : r < 80 ? station_mac : 48'({$urandom, $urandom});
    if (k < 40) etype = efc_pkg::ETYPE_ARP;
    else if (k < 85) etype = efc_pkg::ETYPE_IPV4;
    else if (k < 92) etype = efc_pkg::ETYPE_ARP ^ (16'h1 << $urandom_range(15));
    else etype = 16'($urandom);
    op = $urandom_range(99) < 80 ? efc_pkg::ARP_OP_REQUEST : 16'($urandom);
    r = $urandom_range(99);
    proto = r < 40 ? efc_pkg::PROTO_TCP : r < 80 ? efc_pkg::PROTO_UDP : 8'($urandom);
    r = $urandom_range(99);
    if (r < 80) addr = station_ip;
    else if (r < 90) addr = station_ip ^ (32'h1 << $urandom_range(31));
    else addr = $urandom;
    send_frame(build_frame(dmac, etype, 16'($urandom), op, proto, addr, len));
  endtask

  task automatic test_random_traffic;
    int start_bytes;
    int start_frames;
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) write_station('1, '1);
      else if (phase == 1) write_station('0, '0);
      else write_station(48'({$urandom, $urandom}), $urandom);
      quiet = (phase == 2);
      start_bytes = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < 80 || frames_sent - start_frames < 3) begin
        send_random_frame();
        if (phase == 3 && frames_sent - start_frames == 2) wait_results_done();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= efc_pkg::CFG_OWN_MAC;
    cfg_data  <= '0;
    quiet = 1'b0;
    fails = 0;
    bytes_sent = 0;
    frames_sent = 0;
    station_mac = '0;
    station_ip = '0;
    clear_capture();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_station();
    test_arp_requests();
    test_ipv4_traffic();
    test_runt_and_long_frames();
    test_random_traffic();

    wait_results_done();
    repeat (8) @(posedge clk);
    $display("tb: %0d bytes in %0d frames; station set to extremes and random values",
             bytes_sent, frames_sent);
    $display("tb: results checked by class arp %0d, tcp %0d, udp %0d, other %0d",
             class_seen[efc_pkg::CLASS_ARP], class_seen[efc_pkg::CLASS_TCP],
             class_seen[efc_pkg::CLASS_UDP], class_seen[efc_pkg::CLASS_OTHER]);
    if (fails == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/efc_pkg.sv
design/ethernet_frame_classifier_unit.sv
verif/tb.sv
